// ----- hdl/tte_pkg.sv -----
// Package for the timer table: command codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package tte_pkg;

  localparam int unsigned TimeW = 48;
  localparam int unsigned PerW  = 32;
  localparam int unsigned MaxOut = 16;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [2:0] {
    CMD_ADD     = 3'd0,
    CMD_CANCEL  = 3'd1,
    CMD_REFRESH = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_EXPIRE  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;       // capture the item and clear the scan
    logic scan_step;  // examine one slot
    logic apply;      // perform the single-slot update and emit
    logic emit_pick;  // emit the current expiry pick and update its slot
    logic emit_none;  // emit the closing word of an expire with no due timer
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_last;  // current scan slot is the last one
    logic is_expire;
    logic found;      // the finished expire scan found a due timer
  } dp_stat_t;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [PerW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {{(TimeW-PerW+1){1'b0}}, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

// ----- hdl/tte_ctrl.sv -----
// Controller for the timer table: sequences the per-slot scans and the
// result words. Depends on tte_pkg.
module tte_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output tte_pkg::dp_cmd_t  cmd_o,
  input  tte_pkg::dp_stat_t stat_i
);
  import tte_pkg::*;

  state_t state_r, state_nxt;
  logic [4:0] n_r, n_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    cmd_o     = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          n_nxt      = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_nxt = stat_i.is_expire ? ST_EMIT : ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_EMIT: begin
        if (stat_i.found) begin
          cmd_o.emit_pick = 1'b1;
          n_nxt = n_r + 5'd1;
          state_nxt = (n_r == 5'(MaxOut - 1)) ? ST_DONE : ST_SCAN;
        end else begin
          if (n_r == '0) begin
            cmd_o.emit_none = 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/tte_dp.sv -----
// Datapath for the timer table: slot registers, the one-slot-a-cycle scan
// and the result register. Depends on tte_pkg.
module tte_dp #(
  parameter int unsigned SLOTS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [2:0]                in_cmd,
  input  logic [3:0]                in_slot_id,
  input  logic [31:0]               in_period_ms,
  input  logic                      in_repeat_req,
  input  logic [47:0]               in_now_ms,
  input  tte_pkg::dp_cmd_t          cmd_i,
  output tte_pkg::dp_stat_t         stat_o,
  output logic                      out_valid,
  output logic [3:0]                out_slot,
  output logic                      out_ok,
  output logic [47:0]               out_wait_ms,
  output logic                      out_any_active,
  output logic                      out_first_changed,
  output logic                      out_last
);
  import tte_pkg::*;

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TimeW-1:0] deadline_r [SLOTS];
  logic [PerW-1:0]  period_r   [SLOTS];
  logic [SLOTS-1:0] reloads_r, active_r, done_r;

  logic [2:0]       cmd_r;
  logic [3:0]       id_r;
  logic [PerW-1:0]  per_r;
  logic             rep_r;
  logic [TimeW-1:0] now_r;

  logic [SW-1:0]    idx_r;
  // Scan result: best slot, its key and whether any was found.
  logic             hit_r;
  logic [SW-1:0]    pick_r;
  logic [TimeW-1:0] best_r;
  // For add: lowest free slot.
  logic             free_hit_r;
  logic [SW-1:0]    free_r;

  logic             ov_r, ok_r, any_r, fc_r, last_r;
  logic [3:0]       os_r;
  logic [TimeW-1:0] ow_r;

  // Target slot and the deadline it gets on add or refresh.
  logic [SW-1:0]    tgt;
  logic             tgt_ok;
  logic [TimeW-1:0] new_dl;
  logic             cand, better, beats_new, tie_lo;

  always_comb begin
    tgt    = (cmd_r == CMD_ADD) ? free_r : SW'(id_r);
    tgt_ok = (cmd_r == CMD_ADD) ? free_hit_r
                                : (({28'd0, id_r} < SLOTS) && active_r[tgt]);
    new_dl = sat_add(now_r, (cmd_r == CMD_ADD) ? per_r : period_r[tgt]);
    // Expiry and query both look for the earliest active entry.
    cand   = active_r[idx_r] && !done_r[idx_r] &&
             ((cmd_r != CMD_EXPIRE) || (deadline_r[idx_r] <= now_r));
    better = cand && (!hit_r || deadline_r[idx_r] < best_r);
    // On add the new slot is the lowest free one, so an active slot sits below
    // it exactly when no free slot has been seen yet in this scan.
    tie_lo = (cmd_r == CMD_ADD) ? !free_hit_r : (idx_r < tgt);
    // For first_changed: another active slot orders before the target.
    beats_new = active_r[idx_r] && ((cmd_r == CMD_ADD) || (idx_r != tgt)) &&
                ((deadline_r[idx_r] < new_dl) ||
                 ((deadline_r[idx_r] == new_dl) && tie_lo));
  end

  assign stat_o.scan_last = (idx_r == SW'(SLOTS - 1));
  assign stat_o.is_expire = (cmd_r == CMD_EXPIRE);
  assign stat_o.found     = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      reloads_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        deadline_r[i] <= '0;
        period_r[i]   <= '0;
      end
    end else begin
      ov_r <= cmd_i.apply || cmd_i.emit_pick || cmd_i.emit_none;
      if (cmd_i.load) begin
        cmd_r <= in_cmd;
        id_r  <= in_slot_id;
        per_r <= in_period_ms;
        rep_r <= in_repeat_req;
        now_r <= in_now_ms;
        idx_r <= '0;
        hit_r <= 1'b0;
        free_hit_r <= 1'b0;
        done_r <= '0;
        fc_r  <= 1'b1;
      end
      if (cmd_i.scan_step) begin
        idx_r <= (idx_r == SW'(SLOTS - 1)) ? '0 : idx_r + 1'b1;
        if (better) begin
          hit_r  <= 1'b1;
          pick_r <= idx_r;
          best_r <= deadline_r[idx_r];
        end
        if (!active_r[idx_r] && !free_hit_r) begin
          free_hit_r <= 1'b1;
          free_r     <= idx_r;
        end
        if (beats_new) begin
          fc_r <= 1'b0;
        end
      end
      if (cmd_i.apply) begin
        os_r <= '0; ok_r <= 1'b0; ow_r <= '0;
        any_r <= 1'b0; last_r <= 1'b1;
        fc_r <= fc_r && tgt_ok && ((cmd_r == CMD_ADD) || (cmd_r == CMD_REFRESH));
        unique case (cmd_r)
          CMD_ADD, CMD_REFRESH: begin
            if (tgt_ok) begin
              ok_r <= 1'b1;
              deadline_r[tgt] <= new_dl;
              if (cmd_r == CMD_ADD) begin
                os_r <= 4'(tgt);
                active_r[tgt]  <= 1'b1;
                period_r[tgt]  <= per_r;
                reloads_r[tgt] <= rep_r;
              end
            end
          end
          CMD_CANCEL: begin
            if (tgt_ok) begin
              ok_r <= 1'b1;
              active_r[tgt] <= 1'b0;
            end
          end
          CMD_QUERY: begin
            any_r <= hit_r;
            ow_r  <= !hit_r ? TimeMax : (best_r > now_r ? best_r - now_r : '0);
          end
          default: ;
        endcase
      end
      if (cmd_i.emit_pick) begin
        os_r <= 4'(pick_r); ok_r <= 1'b1; ow_r <= '0;
        any_r <= 1'b0; fc_r <= 1'b0; last_r <= 1'b0;
        done_r[pick_r] <= 1'b1;
        hit_r <= 1'b0;
        if (reloads_r[pick_r]) begin
          deadline_r[pick_r] <= sat_add(deadline_r[pick_r], period_r[pick_r]);
        end else begin
          active_r[pick_r] <= 1'b0;
        end
      end
      if (cmd_i.emit_none) begin
        os_r <= '0; ok_r <= 1'b0; ow_r <= '0;
        any_r <= 1'b0; fc_r <= 1'b0; last_r <= 1'b1;
      end
    end
  end

  // The last pick is known only when the next scan finds nothing or the cap is
  // reached, so each expire pick is held until it is known; the last sets last.
  logic       hv_r;
  logic [3:0] hs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
    end else if (cmd_i.load) begin
      hv_r <= 1'b0;
    end else if (cmd_i.emit_pick) begin
      hv_r <= 1'b1;
      hs_r <= 4'(pick_r);
    end else if (hv_r && !cmd_i.scan_step) begin
      hv_r <= 1'b0;
    end
  end

  always_comb begin
    out_valid = 1'b0; out_slot = '0; out_ok = 1'b0; out_wait_ms = '0;
    out_any_active = 1'b0; out_first_changed = 1'b0; out_last = 1'b0;
    if (cmd_r == CMD_EXPIRE && hv_r && !cmd_i.scan_step) begin
      // Previous pick; last when no further pick follows.
      out_valid = 1'b1;
      out_slot  = hs_r;
      out_ok    = 1'b1;
      out_last  = !cmd_i.emit_pick;
    end else if (ov_r && !(cmd_r == CMD_EXPIRE && !last_r)) begin
      out_valid = 1'b1;
      out_slot = os_r; out_ok = ok_r; out_wait_ms = ow_r;
      out_any_active = any_r; out_first_changed = fc_r; out_last = last_r;
    end
  end

endmodule

// ----- hdl/timer_table_expiry.sv -----
// Timer table top level. Add, cancel, refresh, query and unknown commands scan
// all slots once and give one result word; busy is low when it appears.
// Expire scans all slots once per word and stops when a scan finds no due
// timer or at the cap of 16 words; busy stays high through the last word
// unless no timer was due. The receiver cannot stall. Synchronous active-low
// reset clears all timers. Uses tte_ctrl, tte_dp.
module timer_table_expiry #(
  parameter int unsigned SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [3:0]  in_slot_id,
  input  logic [31:0] in_period_ms,
  input  logic        in_repeat_req,
  input  logic [47:0] in_now_ms,
  output logic        out_valid,
  output logic [3:0]  out_slot,
  output logic        out_ok,
  output logic [47:0] out_wait_ms,
  output logic        out_any_active,
  output logic        out_first_changed,
  output logic        out_last
);
  import tte_pkg::*;

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic     ctrl_busy;

  tte_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(ctrl_busy),
    .cmd_o(dcmd), .stat_i(dstat)
  );

  tte_dp #(.SLOTS(SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_cmd(in_cmd), .in_slot_id(in_slot_id), .in_period_ms(in_period_ms),
    .in_repeat_req(in_repeat_req), .in_now_ms(in_now_ms),
    .cmd_i(dcmd), .stat_o(dstat),
    .out_valid(out_valid), .out_slot(out_slot), .out_ok(out_ok),
    .out_wait_ms(out_wait_ms), .out_any_active(out_any_active),
    .out_first_changed(out_first_changed), .out_last(out_last)
  );

  // The final word of an item may appear while the controller is idle.
  assign busy = ctrl_busy || (out_valid && !out_last);

endmodule

// ----- hdl/timer_table_expiry_chk.sv -----
// Port-level checker for the timer table, bound to the top level.
// Depends on the top level's ports only.
module timer_table_expiry_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_ok,
  input logic [47:0] out_wait_ms,
  input logic        out_any_active,
  input logic        out_first_changed,
  input logic        out_last
);
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_empty_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_any_active |-> out_wait_ms != 48'hFFFF_FFFF_FFFF || out_ok == 1'b0)
    else $error("wait field inconsistent");
  a_fc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_changed |-> out_ok) else $error("first without ok");
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_last) else $error("last without strobe");
endmodule

bind timer_table_expiry timer_table_expiry_chk u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_ok(out_ok), .out_wait_ms(out_wait_ms),
  .out_any_active(out_any_active), .out_first_changed(out_first_changed),
  .out_last(out_last)
);

// ----- sim/tb.sv -----
// Testbench for timer_table_expiry: drives add, cancel, refresh, query and
// expire commands and checks every result word against a behavioral table.
// Depends on tte_pkg and the timer_table_expiry RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tte_pkg::*;

  localparam int NSLOT = 16;
  localparam logic [47:0] T48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [3:0]  slot;
    logic        ok;
    logic [47:0] wait_ms;
    logic        any_active;
    logic        first_changed;
    logic        last;
  } timer_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [3:0]  in_slot_id = '0;
  logic [31:0] in_period_ms = '0;
  logic        in_repeat_req = 1'b0;
  logic [47:0] in_now_ms = '0;
  logic        out_valid;
  logic [3:0]  out_slot;
  logic        out_ok;
  logic [47:0] out_wait_ms;
  logic        out_any_active;
  logic        out_first_changed;
  logic        out_last;

  timer_table_expiry DUT (.*);

  always #5 clk = ~clk;

  // Table model.
  logic [47:0] tm_deadline [NSLOT];
  logic [31:0] tm_period   [NSLOT];
  logic        tm_reload   [NSLOT];
  logic        tm_active   [NSLOT];
  timer_word_t expected_words[$];
  int          errors = 0;
  logic [47:0] clock_ms = 48'd1000;

  function automatic void queue_word(timer_word_t w);
    expected_words = {expected_words, w};
  endfunction

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? T48 : s[47:0];
  endfunction

  function automatic logic before_slot(int a, int b);
    if (tm_deadline[a] != tm_deadline[b]) return tm_deadline[a] < tm_deadline[b];
    return a < b;
  endfunction

  function automatic logic earliest(int s);
    for (int i = 0; i < NSLOT; i++)
      if (i != s && tm_active[i] && before_slot(i, s)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic timer_word_t mk(logic [3:0] s, logic ok, logic [47:0] w,
                                     logic any, logic fc, logic lst);
    timer_word_t r;
    r.slot = s; r.ok = ok; r.wait_ms = w; r.any_active = any;
    r.first_changed = fc; r.last = lst;
    return r;
  endfunction

  task automatic predict_timer_words(logic [2:0] cmd, logic [3:0] id, logic [31:0] per,
                                     logic rep, logic [47:0] now);
    logic due [NSLOT];
    logic found, any;
    logic [47:0] best;
    int pick, n;
    found = 1'b0; any = 1'b0; best = '0; pick = 0; n = 0;
    case (cmd)
      CMD_ADD: begin
        for (int i = 0; i < NSLOT && !found; i++)
          if (!tm_active[i]) begin
            found = 1'b1;
            tm_active[i] = 1'b1; tm_period[i] = per; tm_reload[i] = rep;
            tm_deadline[i] = add_sat(now, per);
            queue_word(mk(i[3:0], 1, 0, 0, earliest(i), 1));
          end
        if (!found) queue_word(mk(0, 0, 0, 0, 0, 1));
      end
      CMD_CANCEL, CMD_REFRESH: begin
        if (!tm_active[id]) queue_word(mk(0, 0, 0, 0, 0, 1));
        else if (cmd == CMD_CANCEL) begin
          tm_active[id] = 1'b0;
          queue_word(mk(0, 1, 0, 0, 0, 1));
        end else begin
          tm_deadline[id] = add_sat(now, tm_period[id]);
          queue_word(mk(0, 1, 0, 0, earliest(id), 1));
        end
      end
      CMD_QUERY: begin
        for (int i = 0; i < NSLOT; i++)
          if (tm_active[i] && (!any || tm_deadline[i] < best)) begin
            best = tm_deadline[i]; any = 1'b1;
          end
        queue_word(mk(0, 0, !any ? T48 : (best > now ? best - now : 48'd0),
                      any, 0, 1));
      end
      CMD_EXPIRE: begin
        for (int i = 0; i < NSLOT; i++) due[i] = tm_active[i] && tm_deadline[i] <= now;
        while (n < MaxOut) begin
          found = 1'b0;
          for (int i = 0; i < NSLOT; i++)
            if (due[i] && (!found || before_slot(i, pick))) begin
              pick = i; found = 1'b1;
            end
          if (!found) break;
          due[pick] = 1'b0;
          queue_word(mk(pick[3:0], 1, 0, 0, 0, 0));
          n++;
          if (tm_reload[pick]) tm_deadline[pick] = add_sat(tm_deadline[pick], tm_period[pick]);
          else tm_active[pick] = 1'b0;
        end
        if (n == 0) queue_word(mk(0, 0, 0, 0, 0, 1));
        else expected_words[$].last = 1'b1;
      end
      default: queue_word(mk(0, 0, 0, 0, 0, 1));
    endcase
  endtask

  // Sends one word after a random gap and predicts its results once busy is low.
  // With no gap, start stays high from the previous word.
  task automatic send_item(logic [2:0] cmd, logic [3:0] id, logic [31:0] per,
                           logic rep, logic [47:0] now);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      start <= 1'b0;
      in_cmd <= 3'($urandom); in_slot_id <= 4'($urandom);
      in_now_ms <= 48'({$urandom, $urandom});
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1; in_cmd <= cmd; in_slot_id <= id; in_period_ms <= per;
    in_repeat_req <= rep; in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_words(cmd, id, per, rep, now);
  endtask

  always @(posedge clk) begin
    timer_word_t exp_w;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word slot=%0d", out_slot);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_slot !== exp_w.slot) begin
          $error("slot expected %0d got %0d", exp_w.slot, out_slot); errors++;
        end
        if (out_ok !== exp_w.ok) begin
          $error("ok expected %0d got %0d", exp_w.ok, out_ok); errors++;
        end
        if (out_wait_ms !== exp_w.wait_ms) begin
          $error("wait_ms expected %0h got %0h", exp_w.wait_ms, out_wait_ms); errors++;
        end
        if (out_any_active !== exp_w.any_active) begin
          $error("any_active expected %0d got %0d", exp_w.any_active, out_any_active);
          errors++;
        end
        if (out_first_changed !== exp_w.first_changed) begin
          $error("first_changed expected %0d got %0d", exp_w.first_changed,
                 out_first_changed);
          errors++;
        end
        if (out_last !== exp_w.last) begin
          $error("last expected %0d got %0d", exp_w.last, out_last); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_period();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 3));
      1: return $urandom;
      2: return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(0, 400));
    endcase
  endfunction

  task automatic test_directed();
    send_item(CMD_QUERY, 0, 0, 0, 0);                 // empty table
    send_item(CMD_EXPIRE, 0, 0, 0, 0);                // nothing due
    send_item(CMD_CANCEL, 4'd15, 0, 0, 0);            // bad handle
    send_item(CMD_REFRESH, 4'd3, 0, 0, 0);
    send_item(CMD_ADD, 0, 32'hFFFF_FFFF, 1, T48);     // saturating deadline
    send_item(CMD_ADD, 0, 0, 0, 48'd100);
    send_item(CMD_QUERY, 4'd15, 32'hFFFF_FFFF, 1, 48'd200);  // passed deadline
    send_item(CMD_REFRESH, 4'd1, 0, 1, 48'd50);
    send_item(CMD_CANCEL, 4'd0, 0, 0, 0);
    send_item(3'd5, 0, 0, 0, 0);                      // unknown commands
    send_item(3'd7, 4'd15, 32'hFFFF_FFFF, 1, T48);
    // Fill the table; the last add of the loop and the one after it report full.
    for (int i = 0; i < 16; i++) send_item(CMD_ADD, 0, 32'(i % 3), 1'(i % 2), 48'd10);
    send_item(CMD_ADD, 0, 5, 0, 48'd10);
    send_item(CMD_EXPIRE, 0, 0, 0, 48'd20);           // many due, recurring rearm
    send_item(CMD_EXPIRE, 0, 0, 0, T48);
  endtask

  task automatic test_random();
    logic [2:0] cmd;
    for (int k = 0; k < 250; k++) begin
      clock_ms = clock_ms + 48'($urandom_range(0, 60));
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: cmd = CMD_ADD;
        5, 6: cmd = CMD_CANCEL;
        7, 8: cmd = CMD_REFRESH;
        9, 10: cmd = CMD_QUERY;
        15: cmd = 3'($urandom_range(5, 7));
        default: cmd = CMD_EXPIRE;
      endcase
      if ($urandom_range(0, 30) == 0) clock_ms = 48'({$urandom, $urandom});
      send_item(cmd, 4'($urandom), rand_period(), 1'($urandom), clock_ms);
    end
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      tm_deadline[i] = '0; tm_period[i] = '0; tm_reload[i] = 1'b0; tm_active[i] = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_words.size() == 0) begin
      $display("timer_table_expiry test passed");
    end else begin
      $display("timer_table_expiry test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timer_table_expiry test failed");
    $finish;
  end
endmodule
